>>> hdl/ucts_pkg.sv
package ucts_pkg;

  localparam int CharW   = 7;
  localparam int MaxSpell = 4;

  localparam logic [7:0] LeadD0 = 8'hD0;
  localparam logic [7:0] LeadD1 = 8'hD1;
  localparam logic [CharW-1:0] CharUnder = 7'h5F;
  localparam logic [CharW-1:0] CharNone  = 7'h00;

  // Latin spelling of one Russian letter: length and up to four chars,
  // first char in ch[0].
  typedef struct packed {
    logic [2:0]                        len;
    logic [MaxSpell-1:0][CharW-1:0]    ch;
  } spell_t;

  // One queued job: optional leading underscore, up to four chars, end flag.
  typedef struct packed {
    logic                              us;
    logic [2:0]                        nchar;
    logic [MaxSpell-1:0][CharW-1:0]    ch;
    logic                              fin;
  } job_t;

  // Build a spelling from a right-justified string literal.
  function automatic spell_t mk(input logic [2:0] n, input logic [31:0] s);
    spell_t r;
    int     k;
    r.len = n;
    r.ch  = '0;
    for (k = 0; k < MaxSpell; k++) begin
      if (k < int'(n)) begin
        r.ch[k] = s[8*(int'(n)-1-k) +: CharW];
      end
    end
    return r;
  endfunction

  function automatic spell_t spelling(input logic [5:0] idx);
    spell_t r;
    unique case (idx)
      6'd0:  r = mk(3'd1, 32'("a"));
      6'd1:  r = mk(3'd1, 32'("b"));
      6'd2:  r = mk(3'd1, 32'("v"));
      6'd3:  r = mk(3'd1, 32'("g"));
      6'd4:  r = mk(3'd1, 32'("d"));
      6'd5:  r = mk(3'd1, 32'("e"));
      6'd6:  r = mk(3'd2, 32'("zh"));
      6'd7:  r = mk(3'd1, 32'("z"));
      6'd8:  r = mk(3'd1, 32'("i"));
      6'd9:  r = mk(3'd1, 32'("j"));
      6'd10: r = mk(3'd1, 32'("k"));
      6'd11: r = mk(3'd1, 32'("l"));
      6'd12: r = mk(3'd1, 32'("m"));
      6'd13: r = mk(3'd1, 32'("n"));
      6'd14: r = mk(3'd1, 32'("o"));
      6'd15: r = mk(3'd1, 32'("p"));
      6'd16: r = mk(3'd1, 32'("r"));
      6'd17: r = mk(3'd1, 32'("s"));
      6'd18: r = mk(3'd1, 32'("t"));
      6'd19: r = mk(3'd1, 32'("u"));
      6'd20: r = mk(3'd1, 32'("f"));
      6'd21: r = mk(3'd1, 32'("h"));
      6'd22: r = mk(3'd1, 32'("c"));
      6'd23: r = mk(3'd2, 32'("ch"));
      6'd24: r = mk(3'd2, 32'("sh"));
      6'd25: r = mk(3'd4, 32'("shch"));
      6'd27: r = mk(3'd1, 32'("y"));
      6'd29: r = mk(3'd1, 32'("e"));
      6'd30: r = mk(3'd2, 32'("iu"));
      6'd31: r = mk(3'd2, 32'("ia"));
      6'd32: r = mk(3'd2, 32'("io"));
      default: r = mk(3'd0, 32'd0);   // hard/soft signs, unused codes
    endcase
    return r;
  endfunction

endpackage

>>> hdl/ucts_front.sv
module ucts_front
  import ucts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] name_byte,
  input  logic       final_byte,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic lead_held, lead_is_d1, underscore_pending;
  logic lead_held_next, lead_is_d1_next, underscore_pending_next;

  logic       accept;
  logic       match;
  logic [5:0] idx;
  logic       pend_now;
  logic       is_upper, is_lower, is_digit, is_lead;
  spell_t     sp;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Letter lookup for a held lead byte.
  always_comb begin
    match = 1'b0;
    idx   = '0;
    if (!lead_is_d1) begin
      if (name_byte >= 8'h90 && name_byte <= 8'hAF) begin
        match = 1'b1;
        idx   = 6'(name_byte - 8'h90);
      end else if (name_byte >= 8'hB0 && name_byte <= 8'hBF) begin
        match = 1'b1;
        idx   = 6'(name_byte - 8'hB0);
      end else if (name_byte == 8'h81) begin
        match = 1'b1;
        idx   = 6'd32;
      end
    end else begin
      if (name_byte >= 8'h80 && name_byte <= 8'h8F) begin
        match = 1'b1;
        idx   = 6'(name_byte - 8'h80) + 6'd16;
      end else if (name_byte == 8'h91) begin
        match = 1'b1;
        idx   = 6'd32;
      end
    end
  end

  assign sp       = spelling(idx);
  assign is_upper = name_byte >= 8'h41 && name_byte <= 8'h5A;
  assign is_lower = name_byte >= 8'h61 && name_byte <= 8'h7A;
  assign is_digit = name_byte >= 8'h30 && name_byte <= 8'h39;
  assign is_lead  = name_byte == LeadD0 || name_byte == LeadD1;
  assign pend_now = underscore_pending || (lead_held && !match);

  always_comb begin
    q_job                   = '0;
    q_job.fin               = final_byte;
    lead_held_next          = 1'b0;
    lead_is_d1_next         = 1'b0;
    underscore_pending_next = pend_now;
    if (lead_held && match) begin
      if (sp.len != 3'd0) begin
        q_job.us                = pend_now;
        q_job.nchar             = sp.len;
        q_job.ch                = sp.ch;
        underscore_pending_next = 1'b0;
      end
    end else if (is_lead) begin
      lead_held_next  = 1'b1;
      lead_is_d1_next = name_byte == LeadD1;
    end else if (is_upper || is_lower || is_digit) begin
      q_job.us                = pend_now;
      q_job.nchar             = 3'd1;
      q_job.ch[0]             = is_upper ? CharW'(name_byte + 8'd32) : name_byte[CharW-1:0];
      underscore_pending_next = 1'b0;
    end else begin
      underscore_pending_next = 1'b1;
    end
    if (final_byte) begin
      lead_held_next          = 1'b0;
      lead_is_d1_next         = 1'b0;
      underscore_pending_next = 1'b0;
    end
  end

  // Items with nothing to show and no end mark only touch state.
  assign q_push = accept && (q_job.fin || q_job.nchar != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_held          <= 1'b0;
      lead_is_d1         <= 1'b0;
      underscore_pending <= 1'b0;
    end else if (accept) begin
      lead_held          <= lead_held_next;
      lead_is_d1         <= lead_is_d1_next;
      underscore_pending <= underscore_pending_next;
    end
  end

endmodule

>>> hdl/ucts_queue.sv
module ucts_queue
  import ucts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> hdl/ucts_back.sv
module ucts_back
  import ucts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  job_t             head_job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CharW-1:0] out_char,
  output logic             char_valid,
  output logic             name_end
);

  logic [2:0] step, step_next;
  logic [2:0] total;
  logic       last, load;
  logic [1:0] k;
  logic [CharW-1:0] ch_sel;

  assign total = {2'b00, head_job.us} + head_job.nchar;
  assign last  = (total == 3'd0) || (step == total - 3'd1);
  assign load  = head_valid && (!out_valid || out_ready);
  assign pop   = load && last;
  assign k     = 2'(step - {2'b00, head_job.us});
  assign step_next = last ? 3'd0 : step + 3'd1;

  always_comb begin
    if (head_job.us && step == 3'd0) begin
      ch_sel = CharUnder;
    end else begin
      ch_sel = head_job.ch[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step      <= step_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (total == 3'd0) begin
        out_char   <= CharNone;
        char_valid <= 1'b0;
      end else begin
        out_char   <= ch_sel;
        char_valid <= 1'b1;
      end
      name_end <= head_job.fin && last;
    end
  end

endmodule

>>> hdl/utf8_cyrillic_translit_sanitizer.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    name_byte[7:0], final_byte
// output    out_valid / out_ready  out_char[6:0], char_valid, name_end
//
// Each accepted byte is classified in the same cycle and becomes a job of
// zero to five results; the back end emits one result per cycle while
// out_ready is high, one output item per result (one for a bare end mark).
// A two-entry job queue sits between front and back; in_ready drops only
// when it is full. Bytes with no results and no end mark push no job.
// Synchronous reset clears front state, queue pointers and out_valid.
module utf8_cyrillic_translit_sanitizer
  import ucts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       name_byte,
  input  logic             final_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CharW-1:0] out_char,
  output logic             char_valid,
  output logic             name_end
);

  // front -> queue
  logic q_push, q_full;
  job_t q_job;
  // queue -> back
  logic q_pop, q_head_valid;
  job_t q_head;

  // Front: lead-byte tracking, letter lookup, underscore collapsing.
  ucts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .name_byte  (name_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_job)
  );

  ucts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head)
  );

  // Back: serializes each job into registered output items.
  ucts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_job   (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .char_valid (char_valid),
    .name_end   (name_end)
  );

endmodule
